// ----- hdl/hwcm_pkg.sv -----
// Package: types and constants for the hot water / cooling mode controller.
`default_nettype none
package hwcm_pkg;
  localparam int unsigned AddrWidth = 5;

  localparam logic signed [15:0] SensorFaultCode = 16'sh8000;
  localparam logic [15:0] TimerMax = 16'hFFFF;

  typedef enum logic [2:0] {
    ModeCoolInit  = 3'd0,
    ModeCoolIdle  = 3'd1,
    ModeCoolRun   = 3'd2,
    ModeHwInit    = 3'd3,
    ModeHwMinTime = 3'd4,
    ModeHwRun     = 3'd5,
    ModeHwElement = 3'd6,
    ModeUnused    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    RegReturnDiff   = 3'd0,
    RegOffsetStep   = 3'd1,
    RegOffsetStart  = 3'd2,
    RegMaxPassive   = 3'd3,
    RegMinHotWater  = 3'd4,
    RegElementDelay = 3'd5,
    RegCurveEnable  = 3'd6,
    RegContactEn    = 3'd7
  } reg_e;

  typedef struct packed {
    logic [7:0]  return_difference;
    logic [7:0]  offset_step;
    logic [7:0]  offset_start;
    logic [15:0] max_passive_seconds;
    logic [15:0] min_hot_water_seconds;
    logic [15:0] element_delay_seconds;
    logic        cooling_curve_enable;
    logic        cooling_contact_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] hot_water_temp;
    logic signed [15:0] hot_water_setpoint;
    logic signed [15:0] hot_water_delta;
    logic signed [15:0] buffer_temp;
    logic signed [7:0]  curve_cooling_setpoint;
    logic signed [15:0] fixed_cooling_setpoint;
    logic signed [15:0] return_water_temp;
    logic               dip_switch;
    logic               compressor_running;
    logic               defrost_running;
    logic [4:0]         condition_flags;
  } tick_t;

  typedef struct packed {
    mode_e              mode;
    logic               passive;
    logic               element;
    logic signed [15:0] offset;
    logic               offset_valid;
    logic [15:0]        timer_count;
    logic               timer_running;
    logic               pump_off;
    logic               prev_dip;
    logic               window_armed;
    logic               relay;
    logic signed [15:0] last_heat_sp;
    logic signed [15:0] last_cool_sp;
  } ctl_state_t;

  typedef struct packed {
    logic [2:0]         mode_state;
    logic signed [15:0] heating_setpoint;
    logic signed [15:0] cooling_setpoint;
    logic               heating_mode;
    logic               pump_off;
    logic               element_on;
    logic               cooling_relay_on;
    logic               passive_active;
    logic               setpoints_updated;
  } result_t;
endpackage
`default_nettype wire

// ----- hdl/hwcm_regs.sv -----
// APB register file for the controller configuration.
`default_nettype none
module hwcm_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hwcm_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output hwcm_pkg::cfg_t                      cfg_o
);
  import hwcm_pkg::*;

  cfg_t cfg_q;
  reg_e sel;
  logic wr_en;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.return_difference      <= 8'd2;
      cfg_q.offset_step            <= 8'd20;
      cfg_q.offset_start           <= 8'd0;
      cfg_q.max_passive_seconds    <= 16'd7200;
      cfg_q.min_hot_water_seconds  <= 16'd300;
      cfg_q.element_delay_seconds  <= 16'd7200;
      cfg_q.cooling_curve_enable   <= 1'b0;
      cfg_q.cooling_contact_enable <= 1'b0;
    end else if (wr_en) begin
      case (sel)
        RegReturnDiff:   cfg_q.return_difference      <= pwdata[7:0];
        RegOffsetStep:   cfg_q.offset_step            <= pwdata[7:0];
        RegOffsetStart:  cfg_q.offset_start           <= pwdata[7:0];
        RegMaxPassive:   cfg_q.max_passive_seconds    <= pwdata[15:0];
        RegMinHotWater:  cfg_q.min_hot_water_seconds  <= pwdata[15:0];
        RegElementDelay: cfg_q.element_delay_seconds  <= pwdata[15:0];
        RegCurveEnable:  cfg_q.cooling_curve_enable   <= pwdata[0];
        RegContactEn:    cfg_q.cooling_contact_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      RegReturnDiff:   prdata[7:0]  = cfg_q.return_difference;
      RegOffsetStep:   prdata[7:0]  = cfg_q.offset_step;
      RegOffsetStart:  prdata[7:0]  = cfg_q.offset_start;
      RegMaxPassive:   prdata[15:0] = cfg_q.max_passive_seconds;
      RegMinHotWater:  prdata[15:0] = cfg_q.min_hot_water_seconds;
      RegElementDelay: prdata[15:0] = cfg_q.element_delay_seconds;
      RegCurveEnable:  prdata[0]    = cfg_q.cooling_curve_enable;
      RegContactEn:    prdata[0]    = cfg_q.cooling_contact_enable;
      default:         prdata       = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/hwcm_logic.sv -----
// Next-state and result logic for one control tick.
`default_nettype none
module hwcm_logic (
  input  hwcm_pkg::tick_t      tick_i,
  input  hwcm_pkg::cfg_t       cfg_i,
  input  hwcm_pkg::ctl_state_t st_i,
  output hwcm_pkg::ctl_state_t st_o,
  output hwcm_pkg::result_t    res_o
);
  import hwcm_pkg::*;

  logic signed [17:0] hwt, hsp, hdl, buf_t, rwt, cool_sp, ret_th, off_ext;
  logic steril, thermo, blocked, slot, second, regulate, idle_plant, in_hw;
  logic fault, ge_sp;
  logic updated, heat_mode;
  ctl_state_t s;

  assign hwt   = 18'(tick_i.hot_water_temp);
  assign hsp   = 18'(tick_i.hot_water_setpoint);
  assign hdl   = 18'(tick_i.hot_water_delta);
  assign buf_t = 18'(tick_i.buffer_temp);
  assign rwt   = 18'(tick_i.return_water_temp);
  assign cool_sp = cfg_i.cooling_curve_enable ?
                   18'(tick_i.curve_cooling_setpoint) * 18'sd10 :
                   18'(tick_i.fixed_cooling_setpoint);
  assign ret_th  = cool_sp + $signed({8'd0, cfg_i.return_difference} * 10'd10);
  assign steril   = tick_i.condition_flags[0];
  assign thermo   = tick_i.condition_flags[1];
  assign blocked  = tick_i.condition_flags[2];
  assign slot     = tick_i.condition_flags[3];
  assign second   = tick_i.condition_flags[4];
  assign regulate = !tick_i.dip_switch;
  assign idle_plant = !tick_i.compressor_running && !tick_i.defrost_running;
  assign fault = (tick_i.hot_water_temp == SensorFaultCode) ||
                 (tick_i.hot_water_setpoint == SensorFaultCode) ||
                 (tick_i.hot_water_delta == SensorFaultCode);
  assign in_hw = (st_i.mode >= ModeHwInit) && (st_i.mode <= ModeHwElement);
  assign ge_sp = hwt >= hsp;
  assign off_ext = 18'(st_i.offset);

  always_comb begin
    s = st_i;
    updated = 1'b0;
    heat_mode = 1'b0;
    if (second && s.timer_running && s.timer_count != TimerMax)
      s.timer_count = s.timer_count + 16'd1;
    if (tick_i.dip_switch != s.prev_dip) begin
      s.prev_dip = tick_i.dip_switch;
      if (tick_i.dip_switch) s.pump_off = 1'b0;
    end
    if (slot) begin
      s.window_armed = 1'b1;
    end else if (!regulate || st_i.mode >= ModeHwInit) begin
      s.window_armed = 1'b0;
    end else if (s.window_armed) begin
      if (s.pump_off && buf_t >= ret_th) begin
        s.pump_off = 1'b0;
        s.window_armed = 1'b0;
      end else if (!s.pump_off && buf_t <= cool_sp) begin
        s.pump_off = 1'b1;
        s.window_armed = 1'b0;
      end
    end
    if (fault) begin
    end else if (in_hw && steril) begin
      s.passive = 1'b0;
      s.mode = ModeCoolInit;
    end else if (s.passive && ge_sp) begin
      s.timer_running = 1'b0;
      s.element = 1'b0;
      s.passive = 1'b0;
      s.offset_valid = 1'b0;
    end else if (s.passive && s.timer_running &&
                 s.timer_count >= cfg_i.max_passive_seconds) begin
      s.passive = 1'b0;
      s.mode = ModeCoolInit;
    end else if (!in_hw && !s.passive && hwt < hsp - hdl && !steril && !blocked) begin
      s.mode = ModeHwInit;
    end else begin
      s.last_heat_sp = 16'(hsp + (s.offset_valid ? off_ext : 18'sd0));
      s.last_cool_sp = 16'(cool_sp);
      heat_mode = in_hw;
      updated = 1'b1;
      if (st_i.mode >= ModeHwMinTime && st_i.mode <= ModeHwElement) begin
        if (ge_sp) begin
          s.offset = '0;
          s.offset_valid = 1'b1;
        end else if (s.offset_valid && s.offset != 0 &&
                     rwt >= hsp + off_ext - 18'sd20) begin
          s.offset = s.offset + $signed({8'd0, cfg_i.offset_step});
        end
      end
      case (st_i.mode)
        ModeCoolInit: begin
          if (regulate) s.pump_off = 1'b1;
          if (cfg_i.cooling_contact_enable) s.relay = 1'b1;
          s.mode = ModeCoolIdle;
        end
        ModeCoolIdle: begin
          if (tick_i.compressor_running) begin
            if (regulate) s.pump_off = 1'b0;
            s.mode = ModeCoolRun;
          end
        end
        ModeCoolRun: begin
          if (idle_plant) begin
            if (regulate) s.pump_off = 1'b1;
            s.mode = ModeCoolIdle;
          end
        end
        ModeHwInit: begin
          s.timer_count = '0;
          s.timer_running = 1'b1;
          if (cfg_i.cooling_contact_enable) s.relay = 1'b1;
          s.pump_off = 1'b0;
          s.element = 1'b0;
          s.passive = 1'b0;
          s.offset = $signed({8'd0, cfg_i.offset_start});
          s.offset_valid = 1'b1;
          s.mode = ModeHwMinTime;
        end
        ModeHwMinTime: begin
          if (s.timer_running && s.timer_count >= cfg_i.min_hot_water_seconds)
            s.mode = ModeHwRun;
        end
        ModeHwRun: begin
          if (idle_plant) begin
            s.element = 1'b0; s.timer_running = 1'b0; s.passive = 1'b0;
            s.offset_valid = 1'b0; s.mode = ModeCoolInit;
          end else if (s.timer_running &&
                       s.timer_count >= cfg_i.element_delay_seconds) begin
            s.element = 1'b1;
            s.timer_running = 1'b0;
            s.mode = ModeHwElement;
          end
        end
        ModeHwElement: begin
          if (idle_plant) begin
            s.element = 1'b0; s.timer_running = 1'b0; s.passive = 1'b0;
            s.offset_valid = 1'b0; s.mode = ModeCoolInit;
          end else if (thermo) begin
            s.timer_count = '0;
            s.timer_running = 1'b1;
            s.passive = 1'b1;
            s.offset_valid = 1'b0;
            s.mode = ModeCoolInit;
          end
        end
        default: s.mode = ModeCoolInit;
      endcase
    end
    st_o = s;
    res_o.mode_state        = s.mode;
    res_o.heating_setpoint  = s.last_heat_sp;
    res_o.cooling_setpoint  = s.last_cool_sp;
    res_o.heating_mode      = heat_mode;
    res_o.pump_off          = s.pump_off;
    res_o.element_on        = s.element;
    res_o.cooling_relay_on  = s.relay;
    res_o.passive_active    = s.passive;
    res_o.setpoints_updated = updated;
  end
endmodule
`default_nettype wire

// ----- hdl/hot_water_cooling_mode_controller_core.sv -----
// Top level: hot water / cooling mode controller with stream ports.
//
//  channel   dir  transfer when            payload
//  s_axis    in   s_axis_tvalid & tready   one control tick
//  m_axis    out  m_axis_tvalid & tready   one result per tick
//  apb       in   psel&penable&pwrite      configuration registers 0..7
//
// Result valid in the cycle after transfer; one tick per cycle unless stalled.
// Input is taken whenever the result register is empty or being drained,
// so a tick may enter in the cycle its predecessor's result leaves.
// The state is updated at the tick transfer; the result holds under stall.
// Reset (async, active low) clears mode state and empties the output.
`default_nettype none
module hot_water_cooling_mode_controller_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: hot_water_temp[15:0], hot_water_setpoint[31:16], hot_water_delta[47:32],
  // buffer_temp[63:48], curve_cooling_setpoint[71:64], fixed_cooling_setpoint[87:72],
  // return_water_temp[103:88], dip_switch[104], compressor_running[105],
  // defrost_running[106], condition_flags[111:107]
  input  wire logic [111:0]                   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: mode_state[2:0], heating_setpoint[18:3], cooling_setpoint[34:19],
  // heating_mode[35], pump_off[36], element_on[37], cooling_relay_on[38],
  // passive_active[39], setpoints_updated[40], zero pad[47:41]
  output logic [47:0]                         m_axis_tdata,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hwcm_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import hwcm_pkg::*;

  cfg_t       cfg;
  tick_t      tick;
  ctl_state_t st_q, st_d;
  result_t    res_d, res_q;
  logic       vld_q, take;

  hwcm_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  assign tick.hot_water_temp         = s_axis_tdata[15:0];
  assign tick.hot_water_setpoint     = s_axis_tdata[31:16];
  assign tick.hot_water_delta        = s_axis_tdata[47:32];
  assign tick.buffer_temp            = s_axis_tdata[63:48];
  assign tick.curve_cooling_setpoint = s_axis_tdata[71:64];
  assign tick.fixed_cooling_setpoint = s_axis_tdata[87:72];
  assign tick.return_water_temp      = s_axis_tdata[103:88];
  assign tick.dip_switch             = s_axis_tdata[104];
  assign tick.compressor_running     = s_axis_tdata[105];
  assign tick.defrost_running        = s_axis_tdata[106];
  assign tick.condition_flags        = s_axis_tdata[111:107];

  hwcm_logic u_logic (
    .tick_i(tick), .cfg_i(cfg), .st_i(st_q), .st_o(st_d), .res_o(res_d)
  );

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      if (take) st_q <= st_d;
      if (take) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {7'd0, res_q.setpoints_updated, res_q.passive_active,
                          res_q.cooling_relay_on, res_q.element_on, res_q.pump_off,
                          res_q.heating_mode, res_q.cooling_setpoint,
                          res_q.heating_setpoint, res_q.mode_state};

  // a stalled result must not be overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("overwrite");
  // the unused state code is never stored
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.mode != ModeUnused) else $error("unused mode state");
  // relay, once latched, stays
  a_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_q.relay) |-> st_q.relay) else $error("relay cleared");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the hot water / cooling mode controller: predictor, stream driver and monitor.
`timescale 1ns / 1ps
module tb_top;
  import hwcm_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tdata: hot_water_temp .. condition_flags, lowest bit first (see dut port list)
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata: mode_state, heating_setpoint, cooling_setpoint, flags, zero pad
  logic [47:0]  m_axis_tdata;
  logic         psel, penable, pwrite, pready;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]  pwdata, prdata;

  hot_water_cooling_mode_controller_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor configuration, tracked at each register write
  int cf_ret_diff, cf_off_step, cf_off_start, cf_max_pass, cf_min_hw, cf_elem_delay;
  bit cf_curve_en, cf_contact_en;

  // Predictor state
  logic [2:0] pm_mode;
  bit pm_passive, pm_element, pm_off_valid, pm_timer_run, pm_pump, pm_prev_dip;
  bit pm_armed, pm_relay;
  int pm_off, pm_timer, pm_heat_sp, pm_cool_sp;

  tick_t   tick_q[$];
  result_t result_q[$];
  tick_t   cur_tick;
  int      gap_left, stall_left, hold_left;
  bit      hold_done, idle_en;
  int      n_in, n_out, n_err, n_hw_ticks, n_passive;

  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic bit in_hot_water(logic [2:0] m);
    return m >= ModeHwInit && m <= ModeHwElement;
  endfunction

  task automatic adjust_offset(int hwt, int hsp, int rwt);
    if (hwt >= hsp) begin
      pm_off = 0;
      pm_off_valid = 1;
    end else if (pm_off_valid && pm_off != 0 && rwt >= hsp + pm_off - 20) begin
      pm_off = wrap16(pm_off + cf_off_step);
    end
  endtask

  task automatic drop_hot_water();
    pm_element = 0;
    pm_timer_run = 0;
    pm_passive = 0;
    pm_off_valid = 0;
    pm_mode = ModeCoolInit;
  endtask

  // One control tick through the mode machine; returns the result it should give.
  task automatic predict_tick(input tick_t t, output result_t r);
    int hwt, hsp, hdl, bft, rwt, csp;
    bit dip, comp, steril, thermo, blocked, slot, sec, regulate, quiet_plant, done;
    bit updated, heat_mode;
    hwt = int'(t.hot_water_temp);
    hsp = int'(t.hot_water_setpoint);
    hdl = int'(t.hot_water_delta);
    bft = int'(t.buffer_temp);
    rwt = int'(t.return_water_temp);
    csp = cf_curve_en ? int'(t.curve_cooling_setpoint) * 10 : int'(t.fixed_cooling_setpoint);
    dip = t.dip_switch;
    comp = t.compressor_running;
    quiet_plant = !comp && !t.defrost_running;
    steril = t.condition_flags[0];
    thermo = t.condition_flags[1];
    blocked = t.condition_flags[2];
    slot = t.condition_flags[3];
    sec = t.condition_flags[4];
    regulate = !dip;
    updated = 0;
    heat_mode = 0;
    done = 0;

    if (sec && pm_timer_run && pm_timer < 65535) pm_timer++;
    if (dip != pm_prev_dip) begin
      pm_prev_dip = dip;
      if (dip) pm_pump = 0;
    end

    // cooling pump hysteresis, armed by the regulation slot
    if (slot) begin
      pm_armed = 1;
    end else if (!regulate || pm_mode >= ModeHwInit) begin
      pm_armed = 0;
    end else if (pm_armed) begin
      if (pm_pump && bft >= csp + cf_ret_diff * 10) begin
        pm_pump = 0;
        pm_armed = 0;
      end else if (!pm_pump && bft <= csp) begin
        pm_pump = 1;
        pm_armed = 0;
      end
    end

    // unknown hot water sensors: mode machine skipped, setpoints not updated
    if (hwt == -32768 || hsp == -32768 || hdl == -32768) done = 1;

    if (!done && in_hot_water(pm_mode) && steril) begin
      pm_passive = 0;
      pm_mode = ModeCoolInit;
      done = 1;
    end

    if (!done && pm_passive) begin
      if (hwt >= hsp) begin
        pm_timer_run = 0;
        pm_element = 0;
        pm_passive = 0;
        pm_off_valid = 0;
        done = 1;
      end else if (pm_timer_run && pm_timer >= cf_max_pass) begin
        pm_passive = 0;
        pm_mode = ModeCoolInit;
        done = 1;
      end
    end

    if (!done && !in_hot_water(pm_mode) && !pm_passive && hwt < hsp - hdl &&
        !steril && !blocked) begin
      pm_mode = ModeHwInit;
      done = 1;
    end

    if (!done) begin
      pm_heat_sp = wrap16(hsp + (pm_off_valid ? pm_off : 0));
      pm_cool_sp = wrap16(csp);
      heat_mode = in_hot_water(pm_mode);
      updated = 1;
      case (pm_mode)
        ModeCoolInit: begin
          if (regulate) pm_pump = 1;
          if (cf_contact_en) pm_relay = 1;
          pm_mode = ModeCoolIdle;
        end
        ModeCoolIdle: begin
          if (comp) begin
            if (regulate) pm_pump = 0;
            pm_mode = ModeCoolRun;
          end
        end
        ModeCoolRun: begin
          if (quiet_plant) begin
            if (regulate) pm_pump = 1;
            pm_mode = ModeCoolIdle;
          end
        end
        ModeHwInit: begin
          pm_timer = 0;
          pm_timer_run = 1;
          if (cf_contact_en) pm_relay = 1;
          pm_pump = 0;
          pm_element = 0;
          pm_passive = 0;
          pm_off = cf_off_start;
          pm_off_valid = 1;
          pm_mode = ModeHwMinTime;
        end
        ModeHwMinTime: begin
          adjust_offset(hwt, hsp, rwt);
          if (pm_timer_run && pm_timer >= cf_min_hw) pm_mode = ModeHwRun;
        end
        ModeHwRun: begin
          adjust_offset(hwt, hsp, rwt);
          if (quiet_plant) begin
            drop_hot_water();
          end else if (pm_timer_run && pm_timer >= cf_elem_delay) begin
            pm_element = 1;
            pm_timer_run = 0;
            pm_mode = ModeHwElement;
          end
        end
        ModeHwElement: begin
          adjust_offset(hwt, hsp, rwt);
          if (quiet_plant) begin
            drop_hot_water();
          end else if (thermo) begin
            // thermostat contact: go passive and wait for the tank
            pm_timer = 0;
            pm_timer_run = 1;
            pm_passive = 1;
            pm_off_valid = 0;
            pm_mode = ModeCoolInit;
          end
        end
        default: pm_mode = ModeCoolInit;
      endcase
    end

    if (in_hot_water(pm_mode)) n_hw_ticks++;
    if (pm_passive) n_passive++;
    r.mode_state        = pm_mode;
    r.heating_setpoint  = pm_heat_sp[15:0];
    r.cooling_setpoint  = pm_cool_sp[15:0];
    r.heating_mode      = heat_mode;
    r.pump_off          = pm_pump;
    r.element_on        = pm_element;
    r.cooling_relay_on  = pm_relay;
    r.passive_active    = pm_passive;
    r.setpoints_updated = updated;
  endtask

  function automatic logic [111:0] pack_tick(tick_t t);
    return {t.condition_flags, t.defrost_running, t.compressor_running, t.dip_switch,
            t.return_water_temp, t.fixed_cooling_setpoint, t.curve_cooling_setpoint,
            t.buffer_temp, t.hot_water_delta, t.hot_water_setpoint, t.hot_water_temp};
  endfunction

  function automatic tick_t make_tick(int hwt, int hsp, int hdl, bit comp, logic [4:0] fl);
    tick_t t;
    t.hot_water_temp = hwt[15:0];
    t.hot_water_setpoint = hsp[15:0];
    t.hot_water_delta = hdl[15:0];
    t.buffer_temp = 16'sd120;
    t.curve_cooling_setpoint = 8'sd12;
    t.fixed_cooling_setpoint = 16'sd100;
    t.return_water_temp = hsp[15:0];
    t.dip_switch = 1'b0;
    t.compressor_running = comp;
    t.defrost_running = 1'b0;
    t.condition_flags = fl;
    return t;
  endfunction

  // Mostly plausible plant ticks that walk the hot water cycle; some pure noise.
  function automatic tick_t rand_tick();
    tick_t t;
    int hsp, csp;
    if ($urandom_range(0, 99) < 8) begin
      t = tick_t'(112'({$urandom, $urandom, $urandom, $urandom}));
      t.curve_cooling_setpoint = 8'(int'($urandom_range(0, 200)) - 100);
      return t;
    end
    hsp = $urandom_range(400, 600);
    csp = $urandom_range(50, 200);
    t.hot_water_setpoint = hsp[15:0];
    t.hot_water_temp = 16'(hsp - int'($urandom_range(0, 160)) + 40);
    t.hot_water_delta = 16'($urandom_range(10, 80));
    t.return_water_temp = 16'(hsp + int'($urandom_range(0, 100)) - 40);
    t.buffer_temp = 16'(csp + int'($urandom_range(0, 90)) - 30);
    t.fixed_cooling_setpoint = csp[15:0];
    t.curve_cooling_setpoint = 8'(csp / 10 + int'($urandom_range(0, 4)) - 2);
    t.dip_switch = ($urandom_range(0, 99) < 10);
    t.compressor_running = ($urandom_range(0, 99) < 85);
    t.defrost_running = ($urandom_range(0, 99) < 10);
    t.condition_flags[0] = ($urandom_range(0, 99) < 3);
    t.condition_flags[1] = ($urandom_range(0, 99) < 25);
    t.condition_flags[2] = ($urandom_range(0, 99) < 8);
    t.condition_flags[3] = ($urandom_range(0, 99) < 40);
    t.condition_flags[4] = ($urandom_range(0, 99) < 60);
    case ($urandom_range(0, 49))
      0: t.hot_water_temp = SensorFaultCode;
      1: t.hot_water_setpoint = SensorFaultCode;
      2: t.hot_water_delta = SensorFaultCode;
      default: ;
    endcase
    return t;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Sender: offers queued ticks, with random gaps while idling is enabled
  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      gap_left <= 0;
      n_in <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(cur_tick, r);
        result_q.push_back(r);
        n_in <= n_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 0;
        end else if (tick_q.size() > 0) begin
          cur_tick = tick_q.pop_front();
          s_axis_tdata <= pack_tick(cur_tick);
          s_axis_tvalid <= 1;
          if (idle_en && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 16);
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && n_in >= 300) begin
      hold_done <= 1;
      hold_left <= 300;
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // Monitor: each result transfer checked against the oldest prediction
  always @(posedge clk_i) begin
    result_t e, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.mode_state        = m_axis_tdata[2:0];
      a.heating_setpoint  = m_axis_tdata[18:3];
      a.cooling_setpoint  = m_axis_tdata[34:19];
      a.heating_mode      = m_axis_tdata[35];
      a.pump_off          = m_axis_tdata[36];
      a.element_on        = m_axis_tdata[37];
      a.cooling_relay_on  = m_axis_tdata[38];
      a.passive_active    = m_axis_tdata[39];
      a.setpoints_updated = m_axis_tdata[40];
      n_out++;
      if (result_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = result_q.pop_front();
        if (e != a) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch result %0d: exp mode=%0d hsp=%0d csp=%0d flags=%b, got mode=%0d hsp=%0d csp=%0d flags=%b",
                     n_out, e.mode_state, e.heating_setpoint, e.cooling_setpoint,
                     {e.heating_mode, e.pump_off, e.element_on, e.cooling_relay_on,
                      e.passive_active, e.setpoints_updated},
                     a.mode_state, a.heating_setpoint, a.cooling_setpoint,
                     {a.heating_mode, a.pump_off, a.element_on, a.cooling_relay_on,
                      a.passive_active, a.setpoints_updated});
        end
      end
    end
  end

  task automatic reg_write(reg_e idx, int unsigned val);
    @(posedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= AddrWidth'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      RegReturnDiff:   cf_ret_diff = val & 8'hFF;
      RegOffsetStep:   cf_off_step = val & 8'hFF;
      RegOffsetStart:  cf_off_start = val & 8'hFF;
      RegMaxPassive:   cf_max_pass = val & 16'hFFFF;
      RegMinHotWater:  cf_min_hw = val & 16'hFFFF;
      RegElementDelay: cf_elem_delay = val & 16'hFFFF;
      RegCurveEnable:  cf_curve_en = val[0];
      RegContactEn:    cf_contact_en = val[0];
      default: ;
    endcase
  endtask

  // checked between edges so the sender's updates have settled
  task automatic wait_drained();
    while (tick_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(int unsigned v[8]);
    reg_write(RegReturnDiff, v[0]);
    reg_write(RegOffsetStep, v[1]);
    reg_write(RegOffsetStart, v[2]);
    reg_write(RegMaxPassive, v[3]);
    reg_write(RegMinHotWater, v[4]);
    reg_write(RegElementDelay, v[5]);
    reg_write(RegCurveEnable, v[6]);
    reg_write(RegContactEn, v[7]);
  endtask

  initial begin
    int unsigned cfg[8];
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cf_ret_diff = 2; cf_off_step = 20; cf_off_start = 0; cf_max_pass = 7200;
    cf_min_hw = 300; cf_elem_delay = 7200; cf_curve_en = 0; cf_contact_en = 0;
    pm_mode = ModeCoolInit; pm_passive = 0; pm_element = 0; pm_off = 0;
    pm_off_valid = 0; pm_timer = 0; pm_timer_run = 0; pm_pump = 0; pm_prev_dip = 0;
    pm_armed = 0; pm_relay = 0; pm_heat_sp = 0; pm_cool_sp = 0;
    n_out = 0; n_err = 0; n_hw_ticks = 0; n_passive = 0;
    idle_en = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // short timers so the directed walk reaches element and passive states
    cfg = '{2, 20, 30, 3, 2, 4, 0, 1};
    load_config(cfg);
    tick_q.push_back(make_tick(400, 500, 50, 1, 5'b01000));   // hot water request
    tick_q.push_back(make_tick(400, 500, 50, 1, 5'b00000));   // hot water init
    for (int i = 0; i < 7; i++) tick_q.push_back(make_tick(480, 500, 50, 1, 5'b10000));
    tick_q.push_back(make_tick(480, 500, 50, 1, 5'b00010));   // thermostat -> passive
    for (int i = 0; i < 5; i++) tick_q.push_back(make_tick(450, 500, 50, 1, 5'b10000));
    tick_q.push_back(make_tick(-32768, 500, 50, 1, 5'b00000));
    tick_q.push_back(make_tick(400, -32768, 50, 1, 5'b00000));
    tick_q.push_back(make_tick(400, 500, -32768, 1, 5'b00000));
    tick_q.push_back(make_tick(100, 500, 10, 1, 5'b00000));   // enter hot water
    tick_q.push_back(make_tick(100, 500, 10, 1, 5'b00001));   // sterilisation exit
    tick_q.push_back(make_tick(32767, 32767, 32767, 0, 5'b11111));
    tick_q.push_back(make_tick(-32767, 32767, 0, 0, 5'b00100)); // blocked request
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: cfg = '{2, 20, 0, 7200, 300, 7200, 0, 0};
        1: cfg = '{0, 0, 0, 0, 0, 0, 1, 0};
        2: cfg = '{255, 255, 255, 65535, 65535, 65535, 1, 1};
        3: cfg = '{1, 5, 10, 10, 3, 6, 0, 0};
        4: cfg = '{3, 40, 200, 5, 1, 2, 1, 0};
        default: cfg = '{$urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 20),
                         $urandom_range(0, 8), $urandom_range(0, 12),
                         $urandom_range(0, 1), $urandom_range(0, 1)};
      endcase
      idle_en = (ph != 6);
      load_config(cfg);
      for (int i = 0; i < 200; i++) tick_q.push_back(rand_tick());
      wait_drained();
    end

    $display("ran %0d ticks over 8 register settings, %0d results checked, %0d mismatches",
             n_in, n_out, n_err);
    $display("mode machine spent %0d ticks in hot water and %0d ticks passive",
             n_hw_ticks, n_passive);
    if (n_err == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
